/* rtl/core/epse_pkg.sv */
// Shared types, constants and gear logic for the encoder period speed estimator.
package epse_pkg;

	// Field widths
	localparam int EPSE_CAPTURE_WIDTH = 16;
	localparam int EPSE_FACTOR_W      = 48;
	localparam int EPSE_LIMIT_W       = 31;
	localparam int EPSE_POS_W         = 32;
	localparam int EPSE_SPEED_W       = 32;
	localparam int EPSE_ANGLE_W       = 32;
	localparam int EPSE_IDX_W         = 3;
	localparam int EPSE_CFG_DATA_W    = 48;
	localparam int EPSE_CODE_W        = 3;

	// Register indexes
	typedef enum logic [EPSE_IDX_W-1:0] {
		REG_FACTOR_ONE   = 3'd0,
		REG_FACTOR_TWO   = 3'd1,
		REG_FACTOR_THREE = 3'd2,
		REG_MAX_STEP     = 3'd3,
		REG_MAX_SPEED    = 3'd4,
		REG_POS_WRAP     = 3'd5,
		REG_ANGLE_SCALE  = 3'd6,
		REG_DIR_INVERT   = 3'd7
	} reg_idx_t;

	// Gear codes
	typedef logic [1:0] gear_t;
	localparam gear_t GEAR_LOW  = 2'd0;
	localparam gear_t GEAR_MID  = 2'd1;
	localparam gear_t GEAR_HIGH = 2'd2;

	// Hysteresis thresholds, Q16.16 rad/s
	localparam logic [EPSE_SPEED_W-1:0] RADS_5  = 32'd327680;
	localparam logic [EPSE_SPEED_W-1:0] RADS_15 = 32'd983040;
	localparam logic [EPSE_SPEED_W-1:0] RADS_20 = 32'd1310720;

	// Period below which a still shaft reads as zero speed
	localparam logic [31:0] SLOW_PERIOD = 32'd30000;

	// Prescaler codes per gear
	localparam logic [EPSE_CODE_W-1:0] CLK_CODE_LOW   = 3'd5;
	localparam logic [EPSE_CODE_W-1:0] CLK_CODE_MID   = 3'd4;
	localparam logic [EPSE_CODE_W-1:0] CLK_CODE_HIGH  = 3'd0;
	localparam logic [EPSE_CODE_W-1:0] UNIT_CODE_LOW  = 3'd0;
	localparam logic [EPSE_CODE_W-1:0] UNIT_CODE_HIGH = 3'd2;

	// Gear hysteresis on the speed magnitude; steps apply in order
	function automatic gear_t next_gear(gear_t g, logic [EPSE_SPEED_W-1:0] m);
		gear_t n;
		n = g;
		if (n == GEAR_LOW && m > RADS_15)
			n = GEAR_MID;
		if (n == GEAR_MID) begin
			if (m > RADS_20)
				n = GEAR_HIGH;
			if (m < RADS_5)
				n = GEAR_LOW;
		end
		if (n == GEAR_HIGH && m < RADS_15)
			n = GEAR_MID;
		return n;
	endfunction

endpackage

/* rtl/core/epse_if.sv */
// Channel interfaces: capture event requests, speed results and register writes.
interface epse_in_if #(
	parameter int CAPTURE_WIDTH = epse_pkg::EPSE_CAPTURE_WIDTH
);
	logic                                valid;
	logic                                ready;
	logic [CAPTURE_WIDTH-1:0]            capture_period;
	logic [epse_pkg::EPSE_POS_W-1:0]     position_latch;
	logic                                reverse_direction;
	logic                                capture_overflow;
	logic                                direction_error;
	logic [epse_pkg::EPSE_POS_W-1:0]     position_count;

	modport source (output valid, capture_period, position_latch, reverse_direction,
		capture_overflow, direction_error, position_count, input ready);
	modport sink (input valid, capture_period, position_latch, reverse_direction,
		capture_overflow, direction_error, position_count, output ready);
endinterface

interface epse_out_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [epse_pkg::EPSE_SPEED_W-1:0] speed;
	logic [epse_pkg::EPSE_ANGLE_W-1:0]        electrical_angle;
	logic [1:0]                               speed_range;
	logic [epse_pkg::EPSE_CODE_W-1:0]         clock_prescale_code;
	logic [epse_pkg::EPSE_CODE_W-1:0]         unit_prescale_code;

	modport source (output valid, speed, electrical_angle, speed_range,
		clock_prescale_code, unit_prescale_code, input ready);
	modport sink (input valid, speed, electrical_angle, speed_range,
		clock_prescale_code, unit_prescale_code, output ready);
endinterface

interface epse_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [epse_pkg::EPSE_IDX_W-1:0]       index;
	logic [epse_pkg::EPSE_CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/epse_divider.sv */
// Restoring serial divider, two quotient bits per cycle.
module epse_divider #(
	parameter int DIVIDEND_W = epse_pkg::EPSE_FACTOR_W,
	parameter int DIVISOR_W  = epse_pkg::EPSE_CAPTURE_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  busy,
	output logic [DIVIDEND_W-1:0] quotient
);
	import epse_pkg::*;

	localparam int STEPS = DIVIDEND_W / 2;
	localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W-1:0]  div_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] dq_q;
	logic [DIVISOR_W-1:0]  rem_n;
	logic [DIVIDEND_W-1:0] dq_n;

	// Two restoring steps: dividend bits leave at the top, quotient bits enter at the bottom
	always_comb begin
		logic [DIVISOR_W:0] trial;
		logic [DIVISOR_W:0] diff;
		rem_n = rem_q;
		dq_n  = dq_q;
		for (int i = 0; i < 2; i++) begin
			trial = {rem_n, dq_n[DIVIDEND_W-1]};
			diff  = trial - {1'b0, div_q};
			dq_n  = {dq_n[DIVIDEND_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_n   = diff[DIVISOR_W-1:0];
				dq_n[0] = 1'b1;
			end else begin
				rem_n = trial[DIVISOR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0)
				busy_q <= 1'b0;
		end
	end

	// Datapath shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			dq_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_n;
			dq_q  <= dq_n;
		end
	end

	assign busy     = busy_q;
	assign quotient = dq_q;

endmodule

/* rtl/core/epse_multiplier.sv */
// Shift-add serial multiplier, two multiplier bits per cycle.
module epse_multiplier #(
	parameter int WIDTH = epse_pkg::EPSE_POS_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [WIDTH-1:0]   multiplicand,
	input  logic [WIDTH-1:0]   multiplier,
	output logic               busy,
	output logic [2*WIDTH-1:0] product
);
	import epse_pkg::*;

	localparam int STEPS = WIDTH / 2;
	localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic                 busy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [WIDTH-1:0]     a_q;
	logic [2*WIDTH-1:0]   prod_q;
	logic [WIDTH+1:0]     pp;
	logic [WIDTH+1:0]     sum;

	// Partial product for the low two multiplier bits
	always_comb begin
		case (prod_q[1:0])
			2'd0:    pp = '0;
			2'd1:    pp = {2'b00, a_q};
			2'd2:    pp = {1'b0, a_q, 1'b0};
			2'd3:    pp = {2'b00, a_q} + {1'b0, a_q, 1'b0};
			default: pp = '0;
		endcase
	end

	assign sum = {2'b00, prod_q[2*WIDTH-1:WIDTH]} + pp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0)
				busy_q <= 1'b0;
		end
	end

	// Accumulator in the high half, multiplier shifting out of the low half
	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= multiplicand;
			prod_q <= {{WIDTH{1'b0}}, multiplier};
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[WIDTH-1:2]};
		end
	end

	assign busy    = busy_q;
	assign product = prod_q;

endmodule

/* rtl/core/encoder_period_speed_estimator.sv */
// Encoder period speed estimator: top level with sequencer and result register.
//
// Usage: one request on in_ch carries an encoder capture event (period,
// latched position, direction and error flags, position count). The block
// answers with exactly one result on out_ch: the new speed (signed Q16.16
// rad/s), the electrical angle, the new gear and its prescaler codes.
// Registers are written through cfg (index, data); cfg is always ready and
// should only be written while no request is in flight.
//
// The serial divider (48-bit factor over the capture period, two quotient
// bits per cycle) sets the time from the accepting edge to out_ch.valid;
// the angle multiplier runs alongside it and finishes first. One request
// is worked at a time, so a new request is taken only once the last one
// has left the sequencer.
//
// The result register frees in_ch: a new request is accepted while the
// last result still waits. If the receiver stalls, the next request
// finishes its arithmetic and then waits before its result is written.
// Reset clears the registers, the gear (low range) and the last speed.
module encoder_period_speed_estimator #(
	parameter int CAPTURE_WIDTH = epse_pkg::EPSE_CAPTURE_WIDTH
) (
	input logic   clk,
	input logic   arst_n,
	epse_in_if.sink   in_ch,
	epse_out_if.source out_ch,
	epse_cfg_if.sink  cfg
);
	import epse_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_GEAR,
		S_DIV,
		S_SAT,
		S_SLEW,
		S_LIMIT
	} state_t;

	// Configuration registers
	logic [EPSE_FACTOR_W-1:0] factor_one_q;
	logic [EPSE_FACTOR_W-1:0] factor_two_q;
	logic [EPSE_FACTOR_W-1:0] factor_three_q;
	logic [EPSE_LIMIT_W-1:0]  max_step_q;
	logic [EPSE_LIMIT_W-1:0]  max_speed_q;
	logic [EPSE_POS_W-1:0]    pos_wrap_q;
	logic [EPSE_ANGLE_W-1:0]  angle_scale_q;
	logic                     dir_invert_q;

	// Sequencer and state
	state_t                          state_q;
	gear_t                           gear_q;
	gear_t                           gear_next_q;
	logic signed [EPSE_SPEED_W-1:0]  last_q;
	logic signed [EPSE_SPEED_W-1:0]  est_q;
	logic [EPSE_ANGLE_W-1:0]         angle_q;
	logic                            zero_q;
	logic                            err_q;
	logic                            neg_q;

	// Latched request
	logic [CAPTURE_WIDTH-1:0] period_q;
	logic [EPSE_POS_W-1:0]    poslat_q;
	logic [EPSE_POS_W-1:0]    poscnt_q;
	logic                     rev_q;

	// Result register
	logic                            out_valid_q;
	logic signed [EPSE_SPEED_W-1:0]  out_speed_q;
	logic [EPSE_ANGLE_W-1:0]         out_angle_q;
	logic [1:0]                      out_range_q;
	logic [EPSE_CODE_W-1:0]          out_clk_q;
	logic [EPSE_CODE_W-1:0]          out_unit_q;

	// Arithmetic units
	logic                       div_busy;
	logic [EPSE_FACTOR_W-1:0]   quotient;
	logic                       mul_busy;
	logic [2*EPSE_POS_W-1:0]    product;
	logic                       unit_start;
	logic [EPSE_FACTOR_W-1:0]   factor_sel;

	// Combinational helpers
	logic [EPSE_SPEED_W-1:0]        last_mag;
	gear_t                          gear_n;
	logic                           negative;
	logic                           delta_zero;
	logic [31:0]                    period_ext;
	logic signed [EPSE_SPEED_W:0]   last_ext;
	logic signed [EPSE_SPEED_W:0]   est_ext;
	logic signed [EPSE_SPEED_W:0]   slew_hi;
	logic signed [EPSE_SPEED_W:0]   slew_lo;
	logic signed [EPSE_SPEED_W:0]   lim_hi;
	logic signed [EPSE_SPEED_W:0]   lim_lo;
	logic signed [EPSE_SPEED_W-1:0] sat_est;
	logic signed [EPSE_SPEED_W-1:0] final_est;
	logic [EPSE_CODE_W-1:0]         clk_code;
	logic [EPSE_CODE_W-1:0]         unit_code;
	logic                           out_free;

	assign cfg.ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_one_q   <= '0;
			factor_two_q   <= '0;
			factor_three_q <= '0;
			max_step_q     <= '0;
			max_speed_q    <= '0;
			pos_wrap_q     <= '0;
			angle_scale_q  <= '0;
			dir_invert_q   <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FACTOR_ONE:   factor_one_q   <= cfg.data;
				REG_FACTOR_TWO:   factor_two_q   <= cfg.data;
				REG_FACTOR_THREE: factor_three_q <= cfg.data;
				REG_MAX_STEP:     max_step_q     <= cfg.data[EPSE_LIMIT_W-1:0];
				REG_MAX_SPEED:    max_speed_q    <= cfg.data[EPSE_LIMIT_W-1:0];
				REG_POS_WRAP:     pos_wrap_q     <= cfg.data[EPSE_POS_W-1:0];
				REG_ANGLE_SCALE:  angle_scale_q  <= cfg.data[EPSE_ANGLE_W-1:0];
				REG_DIR_INVERT:   dir_invert_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Gear step on the last speed magnitude
	assign last_mag   = last_q[EPSE_SPEED_W-1] ? (~last_q + 1'b1) : last_q;
	assign gear_n     = next_gear(gear_q, last_mag);
	assign negative   = rev_q ^ dir_invert_q;
	assign delta_zero = rev_q ? (poslat_q == pos_wrap_q) : (poslat_q == '0);
	assign period_ext = 32'(period_q);

	// Factor and codes of the new gear; an invalid gear uses the high range
	always_comb begin
		case (gear_n)
			GEAR_LOW: factor_sel = factor_one_q;
			GEAR_MID: factor_sel = factor_two_q;
			default:  factor_sel = factor_three_q;
		endcase
		case (gear_next_q)
			GEAR_LOW: begin
				clk_code  = CLK_CODE_LOW;
				unit_code = UNIT_CODE_LOW;
			end
			GEAR_MID: begin
				clk_code  = CLK_CODE_MID;
				unit_code = UNIT_CODE_LOW;
			end
			default: begin
				clk_code  = CLK_CODE_HIGH;
				unit_code = UNIT_CODE_HIGH;
			end
		endcase
	end

	assign unit_start = (state_q == S_GEAR);

	epse_divider #(
		.DIVIDEND_W (EPSE_FACTOR_W),
		.DIVISOR_W  (CAPTURE_WIDTH)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (unit_start),
		.dividend (factor_sel),
		.divisor  (period_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	epse_multiplier #(
		.WIDTH (EPSE_POS_W)
	) u_multiplier (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (unit_start),
		.multiplicand (angle_scale_q),
		.multiplier   (poscnt_q),
		.busy         (mul_busy),
		.product      (product)
	);

	// Signed, saturated quotient with zero and hold cases
	always_comb begin
		if (err_q)
			sat_est = last_q;
		else if (zero_q)
			sat_est = '0;
		else if (neg_q) begin
			if (quotient > 48'h0000_8000_0000)
				sat_est = 32'sh8000_0000;
			else
				sat_est = -$signed(quotient[EPSE_SPEED_W-1:0]);
		end else begin
			if (quotient > 48'h0000_7FFF_FFFF)
				sat_est = 32'sh7FFF_FFFF;
			else
				sat_est = $signed(quotient[EPSE_SPEED_W-1:0]);
		end
	end

	// Slew window and speed limit, one bit wider than the speed
	assign last_ext = {last_q[EPSE_SPEED_W-1], last_q};
	assign est_ext  = {est_q[EPSE_SPEED_W-1], est_q};
	assign slew_hi  = last_ext + $signed({2'b00, max_step_q});
	assign slew_lo  = last_ext - $signed({2'b00, max_step_q});
	assign lim_hi   = $signed({2'b00, max_speed_q});
	assign lim_lo   = -lim_hi;
	assign final_est = (est_ext > lim_hi || est_ext < lim_lo) ? last_q : est_q;

	assign out_free = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);

	// Sequencer, datapath registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			gear_q      <= GEAR_LOW;
			gear_next_q <= GEAR_LOW;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Result valid: set when a result is written, cleared when taken
			if (state_q == S_LIMIT && out_free)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid)
						state_q <= S_GEAR;
				end
				S_GEAR: begin
					gear_next_q <= gear_n;
					state_q     <= S_DIV;
				end
				S_DIV: begin
					if (!div_busy && !mul_busy)
						state_q <= S_SAT;
				end
				S_SAT: begin
					state_q <= S_SLEW;
				end
				S_SLEW: begin
					state_q <= S_LIMIT;
				end
				S_LIMIT: begin
					if (out_free) begin
						last_q      <= final_est;
						gear_q      <= gear_next_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid) begin
			period_q <= in_ch.capture_period;
			poslat_q <= in_ch.position_latch;
			poscnt_q <= in_ch.position_count;
			rev_q    <= in_ch.reverse_direction;
			err_q    <= in_ch.capture_overflow | in_ch.direction_error;
		end
		if (state_q == S_GEAR) begin
			neg_q  <= negative;
			zero_q <= (period_q == '0) ||
				(delta_zero && (negative || period_ext < SLOW_PERIOD));
		end
		if (state_q == S_SAT) begin
			est_q <= sat_est;
			if (product[2*EPSE_POS_W-1:EPSE_ANGLE_W+8] != '0)
				angle_q <= '1;
			else
				angle_q <= product[EPSE_ANGLE_W+7:8];
		end
		if (state_q == S_SLEW) begin
			if (est_ext > slew_hi)
				est_q <= slew_hi[EPSE_SPEED_W-1:0];
			else if (est_ext < slew_lo)
				est_q <= slew_lo[EPSE_SPEED_W-1:0];
		end
		if (state_q == S_LIMIT && out_free) begin
			out_speed_q <= final_est;
			out_angle_q <= angle_q;
			out_range_q <= gear_next_q;
			out_clk_q   <= clk_code;
			out_unit_q  <= unit_code;
		end
	end

	assign out_ch.valid               = out_valid_q;
	assign out_ch.speed               = out_speed_q;
	assign out_ch.electrical_angle    = out_angle_q;
	assign out_ch.speed_range         = out_range_q;
	assign out_ch.clock_prescale_code = out_clk_q;
	assign out_ch.unit_prescale_code  = out_unit_q;

endmodule
